>>> design/hqnim_pkg.sv
// Package for the hex/quad node index map: state codes, element kinds, square table.
`default_nettype none

package hqnim_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HEX   = 4'b0010,
        ST_QUAD  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    // Element kind codes on req_type
    localparam logic KIND_QUAD = 1'b0;
    localparam logic KIND_HEX  = 1'b1;

    // Field widths
    localparam int COORD_W = 4;
    localparam int INDEX_W = 12;

    // Squares of an edge's inner node count, for face sizes
    localparam logic [7:0] SQUARE_LUT [16] = '{
        8'd0,   8'd1,   8'd4,   8'd9,   8'd16,  8'd25,  8'd36,  8'd49,
        8'd64,  8'd81,  8'd100, 8'd121, 8'd144, 8'd169, 8'd196, 8'd225
    };

endpackage

`default_nettype wire

>>> design/hex_quad_node_index_map_top.sv
// Top level: hierarchical node number for Lagrange quad and hex lattice points.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_stall     | req_type, coord_i, coord_j, coord_k
//  out     | out_valid / out_stall   | node_index, out_of_range
//  cfg     | cfg_valid / cfg_ready   | element_order
//
//  An item is accepted in idle, then makes one shell pass per sequencer step
//  through the shared accumulator (hex shells, then quad shells of a face),
//  and the flush step moves the result into the output register.
//  Out-of-range items skip the passes and go straight to the flush step.
//  Reset (rst_n low, asynchronous) returns to idle, drops out_valid and sets
//  element_order to 1. in_stall is high while an item is in work; a waiting
//  result holds in the output register while the next item is accepted.
`default_nettype none

module hex_quad_node_index_map_top (
    input  wire                            clk,
    input  wire                            rst_n,
    // input transaction
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire                            req_type,
    input  wire  [hqnim_pkg::COORD_W-1:0]  coord_i,
    input  wire  [hqnim_pkg::COORD_W-1:0]  coord_j,
    input  wire  [hqnim_pkg::COORD_W-1:0]  coord_k,
    // result transaction
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [hqnim_pkg::INDEX_W-1:0]  node_index,
    output logic                           out_of_range,
    // configuration write
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [hqnim_pkg::COORD_W-1:0]  element_order
);

    import hqnim_pkg::*;

    // Registers
    state_t               state_reg, state_next;
    logic [COORD_W-1:0]   order_reg, order_next;
    logic [COORD_W-1:0]   i_reg, i_next;
    logic [COORD_W-1:0]   j_reg, j_next;
    logic [COORD_W-1:0]   k_reg, k_next;
    logic [COORD_W-1:0]   r_reg, r_next;
    logic [INDEX_W-1:0]   base_reg, base_next;
    logic                 bad_reg, bad_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   node_index_reg, node_index_next;
    logic                 out_of_range_reg, out_of_range_next;

    // Working values, 12-bit modular arithmetic
    logic [INDEX_W-1:0]   i12, j12, k12, r12, m12, msq12;
    logic                 ib, jb, kb;
    logic                 i_nz, j_nz, k_nz;
    logic                 in_bad, out_free;
    logic [COORD_W-1:0]   order_eff;

    // Hex pass results
    logic [INDEX_W-1:0]   hx_add;
    logic                 hx_done, hx_face;
    logic [COORD_W-1:0]   qa, qb;
    logic [2:0]           face_sel;
    logic [10:0]          face_prod;

    // Quad pass results
    logic [INDEX_W-1:0]   qd_add;
    logic                 qd_done;

    // Shared accumulator input
    logic [INDEX_W-1:0]   step_add;

    // Port drive
    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign node_index   = node_index_reg;
    assign out_of_range = out_of_range_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // An order written in the accept cycle applies to that item
    assign order_eff = (cfg_valid && cfg_ready) ? element_order : order_reg;

    // Range check on an incoming item
    assign in_bad = (coord_i > order_eff) || (coord_j > order_eff)
                 || ((req_type == KIND_HEX) && (coord_k > order_eff));

    // Current shell geometry
    assign i12   = {{(INDEX_W-COORD_W){1'b0}}, i_reg};
    assign j12   = {{(INDEX_W-COORD_W){1'b0}}, j_reg};
    assign k12   = {{(INDEX_W-COORD_W){1'b0}}, k_reg};
    assign r12   = {{(INDEX_W-COORD_W){1'b0}}, r_reg};
    assign m12   = r12 - 12'd1;
    assign msq12 = {4'd0, SQUARE_LUT[r_reg - 4'd1]};

    assign i_nz = (i_reg != '0);
    assign j_nz = (j_reg != '0);
    assign k_nz = (k_reg != '0);
    assign ib   = !i_nz || (i_reg == r_reg);
    assign jb   = !j_nz || (j_reg == r_reg);
    assign kb   = !k_nz || (k_reg == r_reg);

    // Face size term f * m^2 for the selected face
    assign face_prod = {8'd0, face_sel} * {3'd0, msq12[7:0]};

    // One hex shell pass: vertex, edge, face or peel
    always_comb
    begin
        hx_add   = '0;
        hx_done  = 1'b0;
        hx_face  = 1'b0;
        qa       = '0;
        qb       = '0;
        face_sel = 3'd6;
        if (ib && jb && kb)
        begin
            hx_done = 1'b1;
            hx_add  = i_nz ? (j_nz ? (k_nz ? 12'd6 : 12'd2) : (k_nz ? 12'd5 : 12'd1))
                           : (j_nz ? (k_nz ? 12'd7 : 12'd3) : (k_nz ? 12'd4 : 12'd0));
        end
        else if (jb && kb)
        begin
            hx_done = 1'b1;
            hx_add  = 12'd8 + (j_nz ? (k_nz ? 12'd12 * r12 - 12'd12 - i12
                                            : 12'd6 * r12 - 12'd6 - i12)
                                    : (k_nz ? 12'd8 * r12 - 12'd9 + i12
                                            : i12 - 12'd1));
        end
        else if (ib && kb)
        begin
            hx_done = 1'b1;
            hx_add  = 12'd8 + (k_nz ? (i_nz ? 12'd10 * r12 - 12'd11 + j12
                                            : 12'd9 * r12 - 12'd10 + j12)
                                    : (i_nz ? 12'd3 * r12 - 12'd4 + j12
                                            : r12 - 12'd2 + j12));
        end
        else if (ib && jb)
        begin
            hx_done = 1'b1;
            hx_add  = 12'd8 + (i_nz ? (j_nz ? 12'd6 * r12 - 12'd7 + k12
                                            : 12'd4 * r12 - 12'd5 + k12)
                                    : (j_nz ? 12'd7 * r12 - 12'd8 + k12
                                            : 12'd2 * r12 - 12'd3 + k12));
        end
        else if (ib)
        begin
            hx_face  = 1'b1;
            face_sel = i_nz ? 3'd3 : 3'd2;
            qa       = i_nz ? j_reg - 4'd1 : k_reg - 4'd1;
            qb       = i_nz ? k_reg - 4'd1 : j_reg - 4'd1;
            hx_add   = 12'd8 + 12'd12 * m12 + {1'b0, face_prod};
        end
        else if (jb)
        begin
            hx_face  = 1'b1;
            face_sel = j_nz ? 3'd4 : 3'd1;
            qa       = j_nz ? r_reg - i_reg - 4'd1 : i_reg - 4'd1;
            qb       = k_reg - 4'd1;
            hx_add   = 12'd8 + 12'd12 * m12 + {1'b0, face_prod};
        end
        else if (kb)
        begin
            hx_face  = 1'b1;
            face_sel = k_nz ? 3'd5 : 3'd0;
            qa       = k_nz ? i_reg - 4'd1 : j_reg - 4'd1;
            qb       = k_nz ? j_reg - 4'd1 : i_reg - 4'd1;
            hx_add   = 12'd8 + 12'd12 * m12 + {1'b0, face_prod};
        end
        else
        begin
            // interior: skip the whole shell (vertices, edges, six faces)
            face_sel = 3'd6;
            hx_add   = 12'd8 + 12'd12 * m12 + {1'b0, face_prod};
        end
    end

    // One quad shell pass: vertex, edge or peel
    always_comb
    begin
        qd_add  = '0;
        qd_done = 1'b0;
        if (ib && jb)
        begin
            qd_done = 1'b1;
            qd_add  = i_nz ? (j_nz ? 12'd2 : 12'd1) : (j_nz ? 12'd3 : 12'd0);
        end
        else if (jb)
        begin
            qd_done = 1'b1;
            qd_add  = 12'd4 + (j_nz ? 12'd3 * r12 - 12'd3 - i12 : i12 - 12'd1);
        end
        else if (ib)
        begin
            qd_done = 1'b1;
            qd_add  = 12'd4 + (i_nz ? r12 - 12'd2 + j12 : 12'd4 * r12 - 12'd4 - j12);
        end
        else
        begin
            qd_add = 12'd4 * r12;
        end
    end

    assign step_add = (state_reg == ST_HEX) ? hx_add : qd_add;

    // Sequencer and accumulator
    always_comb
    begin
        state_next        = state_reg;
        order_next        = order_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        r_next            = r_reg;
        base_next         = base_reg;
        bad_next          = bad_reg;
        out_valid_next    = out_valid_reg && out_stall;
        node_index_next   = node_index_reg;
        out_of_range_next = out_of_range_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    order_next = element_order;
                end
                if (in_valid)
                begin
                    i_next    = coord_i;
                    j_next    = coord_j;
                    k_next    = coord_k;
                    r_next    = order_eff;
                    base_next = '0;
                    bad_next  = in_bad;
                    if (in_bad)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (req_type == KIND_HEX)
                    begin
                        state_next = ST_HEX;
                    end
                    else
                    begin
                        state_next = ST_QUAD;
                    end
                end
            end
            ST_HEX:
            begin
                base_next = base_reg + step_add;
                if (hx_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (hx_face)
                begin
                    i_next     = qa;
                    j_next     = qb;
                    r_next     = r_reg - 4'd2;
                    state_next = ST_QUAD;
                end
                else
                begin
                    i_next = i_reg - 4'd1;
                    j_next = j_reg - 4'd1;
                    k_next = k_reg - 4'd1;
                    r_next = r_reg - 4'd2;
                end
            end
            ST_QUAD:
            begin
                base_next = base_reg + step_add;
                if (qd_done)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    i_next = i_reg - 4'd1;
                    j_next = j_reg - 4'd1;
                    r_next = r_reg - 4'd2;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    node_index_next   = base_reg;
                    out_of_range_next = bad_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= 4'd1;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            out_valid_reg <= out_valid_next;
            bad_reg       <= bad_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        i_reg            <= i_next;
        j_reg            <= j_next;
        k_reg            <= k_next;
        r_reg            <= r_next;
        base_reg         <= base_next;
        node_index_reg   <= node_index_next;
        out_of_range_reg <= out_of_range_next;
    end

`ifndef SYNTHESIS
    // an accepted transaction leaves idle on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    // a new result only comes from the flush step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid && out_stall)) |-> $past(state_reg == ST_FLUSH))
        else $error("result appeared without a flush");

    // a flagged result always carries index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (node_index == '0))
        else $error("out-of-range result with nonzero index");

    // shell order only shrinks while peeling
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HEX) || (state_reg == ST_QUAD)) |-> (r_reg <= order_reg))
        else $error("shell order above element order");
`endif

endmodule

`default_nettype wire
